[src/md5bc_pkg.sv]
// Shared types, constants and round tables for the MD5 block compression engine.
`timescale 1ns / 1ps

package md5bc_pkg;

  // Message block geometry
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ROUNDS      = 64;

  // Standard initial chaining value
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Four-word hash state
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } hash_state_t;

  localparam hash_state_t IV_STATE = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

  // Per-round additive constant
  function automatic logic [31:0] round_const(input logic [5:0] rnd);
    logic [31:0] k;
    case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left-rotate amount by round group and step within the group of four
  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word selected by each round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] j;
    logic [3:0] idx;
    j = rnd[3:0];
    case (rnd[5:4])
      2'd0: idx = j;
      2'd1: idx = (j << 2) + j + 4'd1;
      2'd2: idx = (j << 1) + j + 4'd5;
      2'd3: idx = (j << 3) - j;
      default: idx = j;
    endcase
    return idx;
  endfunction

endpackage

[src/md5bc_word_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module md5bc_word_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/md5bc_round.sv]
// One MD5 round step: round function, constant and word add, rotate, shuffle.
`timescale 1ns / 1ps

module md5bc_round (
  input  md5bc_pkg::hash_state_t cur,
  input  logic [31:0]            word,
  input  logic [5:0]             rnd,
  output md5bc_pkg::hash_state_t nxt
);
  import md5bc_pkg::*;

  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] dbl;
  logic [31:0] rot;

  // Select the nonlinear function of the round group
  always_comb begin
    case (rnd[5:4])
      2'd0: f = cur.d ^ (cur.b & (cur.c ^ cur.d));
      2'd1: f = cur.c ^ (cur.d & (cur.b ^ cur.c));
      2'd2: f = cur.b ^ cur.c ^ cur.d;
      2'd3: f = cur.c ^ (cur.b | ~cur.d);
      default: f = '0;
    endcase
  end

  // Sum, rotate and shuffle the state words
  assign t   = cur.a + f + round_const(rnd) + word;
  assign dbl = {t, t} << rot_amount(rnd);
  assign rot = dbl[63:32];

  assign nxt.a = cur.d;
  assign nxt.b = cur.b + rot;
  assign nxt.c = cur.b;
  assign nxt.d = cur.c;

endmodule

[src/md5_block_compression.sv]
// Top level of the MD5 block compression engine: word store, round sequencer, digest output.
// Words 1..15 of a block are taken one per cycle; the 16th starts 64 rounds, one per cycle,
// each fed from the block word RAM read port. After the last round the engine enters the
// final add, which loads the digest buffer; input ready stays low through the rounds and
// the final add, and longer while the previous digest has not fully drained.
// Synchronous active-high reset loads the initial chaining value and clears the word count.
`timescale 1ns / 1ps

module md5_block_compression (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] message_word
  input  logic        s_tuser,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast
);
  import md5bc_pkg::*;

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_RUN     = 2'd1;
  localparam logic [1:0] ST_FINISH  = 2'd2;

  logic [1:0]   state;
  logic [3:0]   word_count;
  logic [5:0]   rnd;
  hash_state_t  work;
  hash_state_t  work_next;
  hash_state_t  cv;
  hash_state_t  cv_sum;
  logic [31:0]  out_buf [4];
  logic [1:0]   out_cnt;
  logic         out_valid;

  logic         s_req;
  logic         m_req;
  logic [3:0]   waddr;
  logic [3:0]   raddr;
  logic [5:0]   rnd_plus;
  logic [31:0]  word_rd;
  hash_state_t  cv_base;

  assign s_tready = (state == ST_COLLECT);
  assign s_req    = s_tvalid && s_tready;
  assign m_req    = out_valid && m_tready;

  // Restart places the word at the head of a fresh block
  assign waddr    = s_tuser ? 4'd0 : word_count;
  assign cv_base  = s_tuser ? IV_STATE : cv;
  assign rnd_plus = rnd + 6'd1;
  assign raddr    = (state == ST_RUN) ? msg_index(rnd_plus) : msg_index(6'd0);

  md5bc_word_ram #(
    .DEPTH (BLOCK_WORDS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (s_req),
    .waddr (waddr),
    .wdata (s_tdata),
    .raddr (raddr),
    .rdata (word_rd)
  );

  md5bc_round u_round (
    .cur  (work),
    .word (word_rd),
    .rnd  (rnd),
    .nxt  (work_next)
  );

  // Fold the working state into the chaining value
  assign cv_sum.a = cv.a + work.a;
  assign cv_sum.b = cv.b + work.b;
  assign cv_sum.c = cv.c + work.c;
  assign cv_sum.d = cv.d + work.d;

  // Sequence collection, rounds and the final add
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      word_count <= '0;
      rnd        <= '0;
      cv         <= IV_STATE;
    end else begin
      case (state)
        ST_COLLECT: begin
          if (s_req) begin
            cv <= cv_base;
            if (waddr == 4'd15) begin
              word_count <= '0;
              rnd        <= '0;
              work       <= cv_base;
              state      <= ST_RUN;
            end else begin
              word_count <= waddr + 4'd1;
            end
          end
        end
        ST_RUN: begin
          work <= work_next;
          rnd  <= rnd_plus;
          if (rnd == 6'(ROUNDS - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold until the previous digest has drained
          if (!out_valid) begin
            cv    <= cv_sum;
            state <= ST_COLLECT;
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

  // Load and drain the digest output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_cnt   <= '0;
    end else if (state == ST_FINISH && !out_valid) begin
      out_valid <= 1'b1;
      out_cnt   <= '0;
    end else if (m_req) begin
      out_cnt <= out_cnt + 2'd1;
      if (out_cnt == 2'd3) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && !out_valid) begin
      out_buf[0] <= cv_sum.a;
      out_buf[1] <= cv_sum.b;
      out_buf[2] <= cv_sum.c;
      out_buf[3] <= cv_sum.d;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_buf[out_cnt];
  assign m_tlast  = (out_cnt == 2'd3);

endmodule

[tb/md5_digest_checker.sv]
// Scoreboard for the MD5 block compression engine: predicts each digest word and compares it.
`timescale 1ns / 1ps

module md5_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] message_word
  input  logic        s_tuser,   // [0] restart
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] digest_word
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  import md5bc_pkg::*;

  // Boolean function used by each quarter of the 64 rounds
  typedef enum logic [1:0] {RF_F, RF_G, RF_H, RF_I} round_fn_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, four per round group
  localparam int SHIFT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0]  blk_words [16];
  hash_state_t  chain;
  logic [3:0]   fill;
  digest_word_t digest_q [$];
  int           mismatches;

  // Run the 64 rounds over blk_words and fold the result into the chaining value
  function automatic hash_state_t md5_compress(input hash_state_t cv);
    logic [31:0] a, b, c, d, f, t;
    int          i, idx, s;
    round_fn_t   fn;
    hash_state_t nxt;
    a = cv.a;
    b = cv.b;
    c = cv.c;
    d = cv.d;
    for (i = 0; i < 64; i++) begin
      fn = round_fn_t'(i >> 4);
      case (fn)
        RF_F: begin
          f = d ^ (b & (c ^ d));
          idx = i;
        end
        RF_G: begin
          f = c ^ (d & (b ^ c));
          idx = (5 * i + 1) & 15;
        end
        RF_H: begin
          f = b ^ c ^ d;
          idx = (3 * i + 5) & 15;
        end
        default: begin
          f = c ^ (b | ~d);
          idx = (7 * i) & 15;
        end
      endcase
      t = a + f + SINE_K[i] + blk_words[idx];
      s = SHIFT[(i >> 4) * 4 + (i & 3)];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    nxt.a = cv.a + a;
    nxt.b = cv.b + b;
    nxt.c = cv.c + c;
    nxt.d = cv.d + d;
    return nxt;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Track both channels at each rising edge
  always @(posedge clk) begin
    digest_word_t want;
    if (rst) begin
      chain = IV_STATE;
      fill = '0;
      digest_q.delete();
    end else begin
      // Check a delivered digest word against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("digest word %h with none predicted", m_tdata));
        end else begin
          want = digest_q.pop_front();
          if (m_tdata !== want.word)
            report_mismatch($sformatf("digest word %h, predicted %h", m_tdata, want.word));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last flag %b, predicted %b", m_tlast, want.last));
        end
      end
      // Store an accepted request; a restart drops any partial block and reloads the IV
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          chain = IV_STATE;
          fill = '0;
        end
        blk_words[fill] = s_tdata;
        if (fill == 4'd15) begin
          chain = md5_compress(chain);
          digest_q.push_back('{chain.a, 1'b0});
          digest_q.push_back('{chain.b, 1'b0});
          digest_q.push_back('{chain.c, 1'b0});
          digest_q.push_back('{chain.d, 1'b1});
        end
        fill = fill + 4'd1;
      end
    end
    fail_count <= mismatches;
    pending <= digest_q.size();
  end

endmodule

[tb/tb_md5_block_compression.sv]
// Testbench top for the MD5 block compression engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_md5_block_compression;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] message_word
  logic        s_tuser;   // [0] restart
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // [31:0] digest_word
  logic        m_tlast;
  int          fail_count;
  int          pending;
  int          words_sent;
  int          burst_left;
  logic [11:0] stall_tick = '0;

  md5_block_compression dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  md5_digest_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Digest receiver: cycle through always-ready, random, fixed-duty and long-stall modes
  always @(negedge clk) begin
    stall_tick <= stall_tick + 12'd1;
    case (stall_tick[9:8])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_tready <= (stall_tick[2:0] < 3'd2);
      default: m_tready <= (stall_tick[5:0] == 6'd0) || ($urandom_range(0, 15) == 0);
    endcase
  end

  // Offer one message word at a falling edge, inserting a random gap between bursts
  task automatic send_word(input logic [31:0] w, input logic restart);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(0, 4) == 0 ? $urandom_range(8, 24) : $urandom_range(1, 5))
        @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 48)
                                                : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  initial begin
    int          nblk, cut, k;
    logic        fresh, flag;
    logic [31:0] w;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    words_sent = 0;
    burst_left = 32;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: partial block abandoned by a mid-block restart, then a full block
    // alternating all-zero and all-one words
    send_word(32'h0000_0000, 1'b1);
    for (k = 0; k < 4; k++) send_word(32'hffff_ffff, 1'b0);
    send_word(32'hffff_ffff, 1'b1);
    for (k = 1; k < 16; k++) send_word((k % 2) ? 32'h0000_0000 : 32'hffff_ffff, 1'b0);

    // Random messages of one to three blocks, mostly well formed
    while (words_sent < 245) begin
      nblk  = $urandom_range(1, 3);
      fresh = ($urandom_range(0, 7) != 0);
      cut   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16 * nblk - 1) : 16 * nblk;
      for (k = 0; k < cut; k++) begin
        case ($urandom_range(0, 9))
          0:       w = 32'h0000_0000;
          1:       w = 32'hffff_ffff;
          2:       w = 32'h1 << $urandom_range(0, 31);
          default: w = $urandom;
        endcase
        flag = (k == 0) ? fresh : ($urandom_range(0, 63) == 0);
        send_word(w, flag);
      end
    end
    s_tvalid <= 1'b0;

    // Drain outstanding digest words, then let the round engine settle
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS md5_block_compression");
    end else begin
      $display("FAIL md5_block_compression");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 300000);
    $display("FAIL md5_block_compression");
    $finish;
  end

endmodule

[files.f]
src/md5bc_pkg.sv
src/md5bc_word_ram.sv
src/md5bc_round.sv
src/md5_block_compression.sv
tb/md5_digest_checker.sv
tb/tb_md5_block_compression.sv
